>>> hdl/gca_pkg.sv
// ----------------------------------------------------------------------------
// gca_pkg
// Shared constants, codes and stream layout of the granule chain allocator.
// ----------------------------------------------------------------------------
package gca_pkg;

    localparam int GRANULES = 68;
    localparam int MAP_AW   = $clog2(GRANULES);
    localparam int ACC_W    = 20;

    localparam logic [7:0]       GRAN_B        = 8'(GRANULES);
    localparam logic [7:0]       FREE_MARK     = 8'hFF;
    localparam logic [7:0]       END_FIRST     = 8'hC0;
    localparam logic [7:0]       END_LAST      = 8'hC9;
    localparam logic [ACC_W-1:0] GRANULE_BYTES = ACC_W'(9 * 256);
    localparam logic [ACC_W-1:0] COUNT_MAX     = ACC_W'(262143);

    typedef enum logic [2:0] {
        ACT_LOAD    = 3'd0,
        ACT_READ    = 3'd1,
        ACT_MEASURE = 3'd2,
        ACT_ALLOC   = 3'd3,
        ACT_FREE    = 3'd4,
        ACT_FSPACE  = 3'd5
    } act_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_CORRUPT  = 2'd1,
        ST_NO_SPACE = 2'd2,
        ST_RD_ONLY  = 2'd3
    } status_t;

    // stream layout
    localparam int IN_DATA_W  = 56;
    localparam int OUT_DATA_W = 40;
    localparam int DIRTY_BIT  = 35;

endpackage

>>> hdl/granule_chain_allocator.sv
// ----------------------------------------------------------------------------
// granule_chain_allocator
// Per word: load and read look up one map entry; measure follows the chain link
// by link; free clears it entry by entry; allocate counts the granules needed,
// then scans the map for free ones; refused or out-of-range words go to the result.
// Next word is taken in the cycle after the result word is loaded.
// One word in flight; the map sits behind one read and one write port.
// Reset: map reads as all free at once through per-entry valid bits.
// ----------------------------------------------------------------------------
module granule_chain_allocator
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // index, entry_value, last_sector_bytes, byte_length, zero pad
    input  logic [gca_pkg::IN_DATA_W-1:0]  s_tdata,
    // action
    input  logic [2:0]                    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // granule_out, byte_count, tail_bytes, map_dirty, zero pad
    output logic [gca_pkg::OUT_DATA_W-1:0] m_tdata,
    // status
    output logic [1:0]                    m_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_RD   = 6'b000010,
        S_USE  = 6'b000100,
        S_CNT  = 6'b001000,
        S_FIN  = 6'b010000,
        S_DONE = 6'b100000
    } state_t;

    localparam int AW = gca_pkg::MAP_AW;
    localparam int CW = gca_pkg::ACC_W;

    state_t               state_reg, state_next;
    gca_pkg::act_t        act_reg, act_next;
    logic [AW-1:0]        g_reg, g_next;
    logic [AW-1:0]        prev_reg, prev_next;
    logic [7:0]           val_reg, val_next;
    logic [15:0]          last_reg, last_next;
    logic [17:0]          rem_reg, rem_next;
    logic [7:0]           needed_reg, needed_next;
    logic [7:0]           taken_reg, taken_next;
    logic [7:0]           links_reg, links_next;
    logic [CW-1:0]        acc_reg, acc_next;
    logic [11:0]          lpart_reg, lpart_next;
    logic [7:0]           ft_reg, ft_next;
    logic                 dirty_reg, dirty_next;
    logic                 wp_reg;
    gca_pkg::status_t     status_reg, status_next;
    logic [7:0]           gout_reg, gout_next;
    logic [17:0]          count_reg, count_next;
    logic [8:0]           tail_reg, tail_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [gca_pkg::OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;
    logic [1:0]           m_tuser_reg, m_tuser_next;

    // link map and its per-entry valid bits
    logic [7:0]           map_mem [gca_pkg::GRANULES];
    logic [7:0]           map_q;
    logic [gca_pkg::GRANULES-1:0] valid_reg;
    logic                 q_valid_reg;
    logic                 mem_re, mem_we;
    logic [AW-1:0]        mem_waddr;
    logic [7:0]           mem_wdata;
    logic [7:0]           rdata;

    // input fields
    logic [7:0]           in_index, in_value;
    logic [15:0]          in_last;
    logic [17:0]          in_size;
    logic [7:0]           in_lsb;
    logic [CW-1:0]        total, fspace;
    logic [11:0]          lpart_m1;
    logic [7:0]           end_code;
    logic [AW:0]          g_inc;

    assign in_index = s_tdata[7:0];
    assign in_value = s_tdata[15:8];
    assign in_last  = s_tdata[31:16];
    assign in_size  = s_tdata[49:32];
    assign in_lsb   = in_size[7:0];

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign m_tuser   = m_tuser_reg;

    assign rdata    = q_valid_reg ? map_q : gca_pkg::FREE_MARK;
    assign total    = acc_reg + CW'(last_reg) + CW'({rdata[3:0], 8'h00});
    assign fspace   = CW'({ft_reg, 11'b0}) + CW'({ft_reg, 8'b0});
    assign lpart_m1 = lpart_reg - 12'd1;
    assign end_code = (lpart_reg == 12'd0) ? gca_pkg::END_FIRST
                    : gca_pkg::END_FIRST + {4'b0, lpart_m1[11:8]};
    assign g_inc    = {1'b0, g_reg} + (AW+1)'(1);

    function automatic logic [17:0] sat_count(input logic [CW-1:0] v);
        sat_count = (v > gca_pkg::COUNT_MAX) ? 18'h3FFFF : v[17:0];
    endfunction

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            map_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            map_q <= map_mem[g_reg];
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        act_next      = act_reg;
        g_next        = g_reg;
        prev_next     = prev_reg;
        val_next      = val_reg;
        last_next     = last_reg;
        rem_next      = rem_reg;
        needed_next   = needed_reg;
        taken_next    = taken_reg;
        links_next    = links_reg;
        acc_next      = acc_reg;
        lpart_next    = lpart_reg;
        ft_next       = ft_reg;
        dirty_next    = dirty_reg;
        status_next   = status_reg;
        gout_next     = gout_reg;
        count_next    = count_reg;
        tail_next     = tail_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = g_reg;
        mem_wdata     = val_reg;

        if (m_tvalid_reg && m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    act_next    = gca_pkg::act_t'(s_tuser);
                    g_next      = in_index[AW-1:0];
                    val_next    = in_value;
                    last_next   = in_last;
                    rem_next    = in_size;
                    needed_next = 8'd0;
                    taken_next  = 8'd0;
                    links_next  = 8'd0;
                    acc_next    = '0;
                    status_next = gca_pkg::ST_OK;
                    gout_next   = 8'd0;
                    count_next  = 18'd0;
                    tail_next   = 9'd0;
                    state_next  = S_DONE;
                    case (gca_pkg::act_t'(s_tuser))
                        gca_pkg::ACT_LOAD:
                        begin
                            if (in_index < gca_pkg::GRAN_B) state_next = S_RD;
                        end
                        gca_pkg::ACT_READ:
                        begin
                            if (in_index < gca_pkg::GRAN_B) state_next = S_RD;
                            else gout_next = gca_pkg::FREE_MARK;
                        end
                        gca_pkg::ACT_MEASURE:
                        begin
                            if (in_index < gca_pkg::GRAN_B) state_next = S_RD;
                            else status_next = gca_pkg::ST_CORRUPT;
                        end
                        gca_pkg::ACT_ALLOC:
                        begin
                            if (wp_reg)
                            begin
                                status_next = gca_pkg::ST_RD_ONLY;
                            end
                            else
                            begin
                                tail_next  = (in_lsb == 8'd0 && in_size != 18'd0)
                                           ? 9'd256 : {1'b0, in_lsb};
                                state_next = S_CNT;
                            end
                        end
                        gca_pkg::ACT_FREE:
                        begin
                            dirty_next = 1'b1;
                            if (in_index < gca_pkg::GRAN_B) state_next = S_RD;
                        end
                        gca_pkg::ACT_FSPACE:
                        begin
                            count_next = sat_count(fspace);
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            // granules needed, one subtract of a granule size per cycle
            S_CNT:
            begin
                if ({1'b0, needed_reg} + 9'd1 > {1'b0, ft_reg})
                begin
                    status_next = gca_pkg::ST_NO_SPACE;
                    tail_next   = 9'd0;
                    state_next  = S_DONE;
                end
                else if (rem_reg <= 18'(gca_pkg::GRANULE_BYTES))
                begin
                    lpart_next  = rem_reg[11:0];
                    needed_next = needed_reg + 8'd1;
                    g_next      = '0;
                    state_next  = S_RD;
                end
                else
                begin
                    rem_next    = rem_reg - 18'(gca_pkg::GRANULE_BYTES);
                    needed_next = needed_reg + 8'd1;
                end
            end

            S_RD:
            begin
                mem_re     = 1'b1;
                state_next = S_USE;
            end

            S_USE:
            begin
                state_next = S_DONE;
                case (act_reg)
                    gca_pkg::ACT_LOAD:
                    begin
                        mem_we  = 1'b1;
                        ft_next = ft_reg - 8'(rdata == gca_pkg::FREE_MARK)
                                         + 8'(val_reg == gca_pkg::FREE_MARK);
                    end
                    gca_pkg::ACT_READ:
                    begin
                        gout_next = rdata;
                    end
                    gca_pkg::ACT_MEASURE:
                    begin
                        if (rdata < gca_pkg::GRAN_B)
                        begin
                            if ({1'b0, links_reg} + 9'd1 >= 9'(gca_pkg::GRANULES))
                            begin
                                status_next = gca_pkg::ST_CORRUPT;
                            end
                            else
                            begin
                                links_next = links_reg + 8'd1;
                                acc_next   = acc_reg + gca_pkg::GRANULE_BYTES;
                                g_next     = rdata[AW-1:0];
                                state_next = S_RD;
                            end
                        end
                        else if (rdata inside {[gca_pkg::END_FIRST:gca_pkg::END_LAST]})
                        begin
                            count_next = sat_count(total);
                        end
                        else
                        begin
                            status_next = gca_pkg::ST_CORRUPT;
                        end
                    end
                    gca_pkg::ACT_FREE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = gca_pkg::FREE_MARK;
                        if (rdata != gca_pkg::FREE_MARK) ft_next = ft_reg + 8'd1;
                        if (rdata < gca_pkg::GRAN_B)
                        begin
                            g_next     = rdata[AW-1:0];
                            state_next = S_RD;
                        end
                    end
                    gca_pkg::ACT_ALLOC:
                    begin
                        state_next = S_RD;
                        g_next     = g_inc[AW-1:0];
                        if (rdata == gca_pkg::FREE_MARK)
                        begin
                            // link the previous granule forward to this one, or report the first one as the head
                            if (taken_reg == 8'd0)
                            begin
                                gout_next = 8'(g_reg);
                            end
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = prev_reg;
                                mem_wdata = 8'(g_reg);
                            end
                            prev_next  = g_reg;
                            taken_next = taken_reg + 8'd1;
                            ft_next    = ft_reg - 8'd1;
                            if (taken_reg + 8'd1 == needed_reg) state_next = S_FIN;
                        end
                        if (g_inc >= (AW+1)'(gca_pkg::GRANULES)) state_next = S_FIN;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            S_FIN:
            begin
                mem_we     = 1'b1;
                mem_waddr  = prev_reg;
                mem_wdata  = end_code;
                dirty_next = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {4'b0, dirty_reg, tail_reg, count_reg, gout_reg};
                    m_tuser_next  = status_reg;
                    state_next    = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            ft_reg       <= gca_pkg::GRAN_B;
            dirty_reg    <= 1'b0;
            wp_reg       <= 1'b0;
            valid_reg    <= '0;
            q_valid_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            ft_reg       <= ft_next;
            dirty_reg    <= dirty_next;
            m_tvalid_reg <= m_tvalid_next;
            m_tdata_reg  <= m_tdata_next;
            m_tuser_reg  <= m_tuser_next;
            if (cfg_valid)
            begin
                wp_reg <= cfg_data;
            end
            if (mem_we)
            begin
                valid_reg[mem_waddr] <= 1'b1;
            end
            if (mem_re)
            begin
                q_valid_reg <= valid_reg[g_reg];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg    <= act_next;
        g_reg      <= g_next;
        prev_reg   <= prev_next;
        val_reg    <= val_next;
        last_reg   <= last_next;
        rem_reg    <= rem_next;
        needed_reg <= needed_next;
        taken_reg  <= taken_next;
        links_reg  <= links_next;
        acc_reg    <= acc_next;
        lpart_reg  <= lpart_next;
        status_reg <= status_next;
        gout_reg   <= gout_next;
        count_reg  <= count_next;
        tail_reg   <= tail_next;
    end

endmodule

>>> hdl/gca_checker.sv
// ----------------------------------------------------------------------------
// gca_checker
// Port-level checks of the granule chain allocator, bound to the top level.
// ----------------------------------------------------------------------------
module gca_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [55:0] s_tdata,
    input logic [2:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic        cfg_data
);

    // stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // one word at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // dirty mark is sticky
    a_dirty_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        m_tdata[gca_pkg::DIRTY_BIT] |=> m_tdata[gca_pkg::DIRTY_BIT])
        else $error("map dirty mark cleared");

    // corrupt chain gives no size
    a_corrupt_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == gca_pkg::ST_CORRUPT |-> m_tdata[25:0] == 26'd0)
        else $error("corrupt chain with nonzero result");

    // refused allocation leaves the result fields clear
    a_refused_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == gca_pkg::ST_NO_SPACE || m_tuser == gca_pkg::ST_RD_ONLY)
        |-> m_tdata[34:0] == 35'd0)
        else $error("refused allocation with nonzero result");

endmodule

bind granule_chain_allocator gca_checker u_gca_checker (.*);
